// ----- design/mrfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfd_pkg: shared types and constants of the meter response frame decoder
// Frame layout, reading kinds, error codes and the words passed between
// the frame assembler, the decoder and the top level.
// ----------------------------------------------------------------------------
package mrfd_pkg;

    localparam int          FRAME_BODY  = 6;      // bytes before the checksum
    localparam int          POS_W       = 3;      // holds positions 0..6
    localparam logic [7:0]  HEADER_BASE = 8'hA0;
    localparam int          READING_W   = 31;

    typedef enum logic [2:0] {
        KIND_VOLTAGE = 3'd0,
        KIND_CURRENT = 3'd1,
        KIND_POWER   = 3'd2,
        KIND_ENERGY  = 3'd3,
        KIND_TEST    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_HEADER   = 2'd1,
        ERR_CHECKSUM = 2'd2,
        ERR_RESERVED = 2'd3
    } err_t;

    // One complete frame, handed from the assembler to the decoder
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] check;
        logic [7:0] sum;
        logic [2:0] kind;
    } frame_t;

    // Decoded result word
    typedef struct packed {
        logic [READING_W-1:0] reading;
        logic [2:0]           kind;
        logic [1:0]           err;
    } result_t;

endpackage

// ----- design/mrfd_assembler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfd_assembler: byte collector of the meter response frame decoder
// Track the byte position, latch the kind, store bytes 0..5, keep the
// running sum and hold each finished frame in a register until taken.
// ----------------------------------------------------------------------------
module mrfd_assembler (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic [2:0]      expected_kind,
    input  logic            restart,
    input  logic            frame_take,
    output logic            frame_valid,
    output mrfd_pkg::frame_t frame
);
    import mrfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [7:0]       sum_reg, sum_next, sum_base;
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       store_reg [FRAME_BODY];
    logic             emit;
    logic             frame_valid_reg, frame_valid_next;
    frame_t           frame_reg, frame_next;

    always_comb
    begin
        pos_eff  = restart ? '0 : pos_reg;
        sum_base = (pos_eff == '0) ? 8'd0 : sum_reg;
        emit     = accept && (pos_eff == POS_W'(FRAME_BODY));

        pos_next  = pos_reg;
        sum_next  = sum_reg;
        kind_next = kind_reg;
        if (accept)
        begin
            if (pos_eff == '0)
            begin
                kind_next = expected_kind;
            end
            if (emit)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_eff + POS_W'(1);
                sum_next = sum_base + rx_byte;
            end
        end

        frame_next.hdr   = store_reg[0];
        frame_next.b1    = store_reg[1];
        frame_next.b2    = store_reg[2];
        frame_next.b3    = store_reg[3];
        frame_next.b4    = store_reg[4];
        frame_next.b5    = store_reg[5];
        frame_next.check = rx_byte;
        frame_next.sum   = sum_reg;
        frame_next.kind  = kind_reg;

        if (emit)
        begin
            frame_valid_next = 1'b1;
        end
        else if (frame_take)
        begin
            frame_valid_next = 1'b0;
        end
        else
        begin
            frame_valid_next = frame_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            sum_reg         <= '0;
            kind_reg        <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            kind_reg        <= kind_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BODY; i++)
        begin
            if (accept && !emit && (pos_eff == POS_W'(i)))
            begin
                store_reg[i] <= rx_byte;
            end
        end
        if (emit)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ----- design/mrfd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfd_decode: frame decoder of the meter response frame decoder
// Check header, checksum and reserved bytes in priority order and scale
// the reading to hundredths for the latched kind.
// ----------------------------------------------------------------------------
module mrfd_decode (
    input  mrfd_pkg::frame_t  frame,
    output mrfd_pkg::result_t result
);
    import mrfd_pkg::*;

    logic [READING_W-1:0] word_scaled;
    logic [READING_W-1:0] energy_scaled;
    logic [READING_W-1:0] value;
    logic                 reserved_ok;
    logic [7:0]           hdr_expect;
    err_t                 err;

    always_comb
    begin
        word_scaled   = READING_W'({frame.b1, frame.b2}) * READING_W'(100);
        energy_scaled = READING_W'({frame.b1, frame.b2, frame.b3}) * READING_W'(100);
        hdr_expect    = HEADER_BASE + {5'd0, frame.kind};

        case (kind_t'(frame.kind))
            KIND_VOLTAGE:
            begin
                value       = word_scaled + READING_W'(frame.b3) * READING_W'(10);
                reserved_ok = (frame.b4 == 8'd0) && (frame.b5 == 8'd0);
            end
            KIND_CURRENT:
            begin
                value       = word_scaled + READING_W'(frame.b3);
                reserved_ok = (frame.b4 == 8'd0) && (frame.b5 == 8'd0);
            end
            KIND_POWER:
            begin
                value       = word_scaled;
                reserved_ok = (frame.b3 == 8'd0) && (frame.b4 == 8'd0)
                              && (frame.b5 == 8'd0);
            end
            KIND_ENERGY:
            begin
                value       = energy_scaled;
                reserved_ok = (frame.b4 == 8'd0) && (frame.b5 == 8'd0);
            end
            default:
            begin
                // test and undefined kinds: no value, bytes 1..5 reserved
                value       = '0;
                reserved_ok = (frame.b1 == 8'd0) && (frame.b2 == 8'd0)
                              && (frame.b3 == 8'd0) && (frame.b4 == 8'd0)
                              && (frame.b5 == 8'd0);
            end
        endcase

        if (frame.hdr != hdr_expect)
        begin
            err = ERR_HEADER;
        end
        else if (frame.check != frame.sum)
        begin
            err = ERR_CHECKSUM;
        end
        else if (!reserved_ok)
        begin
            err = ERR_RESERVED;
        end
        else
        begin
            err = ERR_NONE;
        end

        result.reading = (err == ERR_NONE) ? value : '0;
        result.kind    = frame.kind;
        result.err     = err;
    end

endmodule

// ----- design/meter_response_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_response_frame_decoder_unit: power meter reply frame decoder
// Collect a 7-byte meter reply and emit one decoded reading per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one reply byte per word with
//   the requested kind and a restart flag. Kind is sampled on frame byte
//   zero; restart forces the word to be byte zero and never yields a result.
//   The seventh byte (checksum) closes the frame; bytes 0..5 yield nothing.
//   Output channel (out_valid / out_stall) carries reading (hundredths),
//   reading_kind and error_code (header, then checksum, then reserved).
// Throughput: one byte per cycle, sustained, as long as results drain.
// Path: the accepted checksum byte closes the frame into the frame register;
//   the decoded result moves into the result register once it is free and
//   shows on out_valid (two register stages: frame, then result register).
// Stall: a stalled result holds in the result register; one more frame may
//   wait in the frame register, and in_stall rises only when both are full.
// Reset: byte position, running sum, latched kind and both valid flags
//   clear; frame bytes are payload and need no reset.
// ----------------------------------------------------------------------------
module meter_response_frame_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  expected_kind,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] reading,
    output logic [2:0]  reading_kind,
    output logic [1:0]  error_code
);
    import mrfd_pkg::*;

    logic    accept;
    logic    frame_valid;
    logic    frame_take;
    logic    out_ready;
    frame_t  frame;
    result_t result;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    // Result register is free when empty or being drained this cycle
    assign out_ready  = !out_valid_reg || !out_stall;
    assign frame_take = frame_valid && out_ready;
    // Hold the input only when a finished frame cannot move on
    assign in_stall   = frame_valid && !out_ready;
    assign accept     = in_valid && !in_stall;

    mrfd_assembler u_assembler (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .expected_kind (expected_kind),
        .restart       (restart),
        .frame_take    (frame_take),
        .frame_valid   (frame_valid),
        .frame         (frame)
    );

    mrfd_decode u_decode (
        .frame  (frame),
        .result (result)
    );

    always_comb
    begin
        if (frame_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance the result word only when a frame moves in
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reading      = result_reg.reading;
    assign reading_kind = result_reg.kind;
    assign error_code   = result_reg.err;

endmodule

// ----- design/mrfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfd_checker: port checks of the meter response frame decoder
// Watch the output channel for held results and consistent readings.
// ----------------------------------------------------------------------------
module mrfd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [30:0] reading,
    input  logic [2:0]  reading_kind,
    input  logic [1:0]  error_code
);
    import mrfd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(reading) && $stable(reading_kind)
                                   && $stable(error_code))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_NONE) |-> reading == '0)
        else $error("nonzero reading on error");

    a_test_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_kind[2] |-> reading == '0)
        else $error("nonzero reading for test kind");

endmodule

bind meter_response_frame_decoder_unit mrfd_checker u_mrfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reading      (reading),
    .reading_kind (reading_kind),
    .error_code   (error_code)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the meter response frame decoder
// Feed reply bytes framed as 7-byte meter replies (well-formed frames with
// random content and injected faults, cut-off frames and loose noise bytes),
// predict each decoded reading in the bench and check every result word
// field by field, in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import mrfd_pkg::*;

    localparam int WORD_TARGET = 1650;   // stop generating past this many words
    localparam int CALM_TAIL   = 150;    // last words run with no idling
    localparam int STALL_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int FRAME_LEN   = FRAME_BODY + 1;

    // Fault injection masks for generated frames
    localparam logic [2:0] FLAW_NONE     = 3'b000;
    localparam logic [2:0] FLAW_HEADER   = 3'b001;
    localparam logic [2:0] FLAW_SUM      = 3'b010;
    localparam logic [2:0] FLAW_RESERVED = 3'b100;

    typedef struct {
        logic [7:0]  b;
        logic [2:0]  k;
        logic        r;
        int unsigned gap;     // idle cycles ahead of this word
        bit          drain;   // hold this word until every reading is back
    } reply_word_t;

    typedef struct {
        logic [READING_W-1:0] reading;
        logic [2:0]           kind;
        err_t                 err;
    } meter_reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic [2:0]  expected_kind = 3'd0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [30:0] reading;
    logic [2:0]  reading_kind;
    logic [1:0]  error_code;

    meter_response_frame_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .expected_kind (expected_kind),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reading       (reading),
        .reading_kind  (reading_kind),
        .error_code    (error_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    reply_word_t    words_to_send [$];
    meter_reading_t readings_due [$];
    int unsigned    fails = 0;
    bit             calm = 1'b0;      // set for the tail of the run: no idling

    // ------------------------------------------------------------------------
    // Frame tracker: mirror of the decoder's byte position, sum, stored bytes
    // and latched kind, advanced once per accepted word.
    // ------------------------------------------------------------------------
    logic [2:0] frame_pos = 3'd0;
    logic [7:0] frame_sum = 8'd0;
    logic [7:0] frame_bytes [FRAME_BODY];
    logic [2:0] frame_kind = 3'd0;

    function automatic meter_reading_t decode_frame(logic [7:0] check);
        meter_reading_t res;
        int unsigned    value;
        int             first_res;
        logic [7:0]     hdr_want;
        bit             res_clear;
        value = 0;
        first_res = 1;
        res_clear = 1'b1;
        case (kind_t'(frame_kind))
            KIND_VOLTAGE:
            begin
                value = {16'd0, frame_bytes[1], frame_bytes[2]} * 32'd100
                      + {24'd0, frame_bytes[3]} * 32'd10;
                first_res = 4;
            end
            KIND_CURRENT:
            begin
                value = {16'd0, frame_bytes[1], frame_bytes[2]} * 32'd100
                      + {24'd0, frame_bytes[3]};
                first_res = 4;
            end
            KIND_POWER:
            begin
                value = {16'd0, frame_bytes[1], frame_bytes[2]} * 32'd100;
                first_res = 3;
            end
            KIND_ENERGY:
            begin
                value = {8'd0, frame_bytes[1], frame_bytes[2], frame_bytes[3]} * 32'd100;
                first_res = 4;
            end
            default:
            begin
                // test and the undefined kinds decode to zero, bytes 1..5 reserved
                value = 0;
                first_res = 1;
            end
        endcase
        for (int i = first_res; i < FRAME_BODY; i++)
            if (frame_bytes[i] != 8'd0)
                res_clear = 1'b0;
        hdr_want = HEADER_BASE + {5'd0, frame_kind};
        if (frame_bytes[0] != hdr_want)
            res.err = ERR_HEADER;
        else if (check != frame_sum)
            res.err = ERR_CHECKSUM;
        else if (!res_clear)
            res.err = ERR_RESERVED;
        else
            res.err = ERR_NONE;
        if (res.err != ERR_NONE)
            value = 0;
        res.reading = value[READING_W-1:0];
        res.kind = frame_kind;
        return res;
    endfunction

    function automatic void absorb_reply_byte(logic [7:0] b, logic [2:0] k, logic r);
        if (r)
            frame_pos = 3'd0;
        if (frame_pos == 3'd0)
        begin
            frame_kind = k;
            frame_sum = 8'd0;
        end
        if (frame_pos < FRAME_BODY)
        begin
            frame_bytes[frame_pos] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 3'd1;
        end
        else
        begin
            readings_due.push_back(decode_frame(b));
            frame_pos = 3'd0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation. gen_pos follows the byte position the decoder will
    // be at, so a frame that follows noise or a cut-off frame resyncs by
    // restart on its first byte.
    // ------------------------------------------------------------------------
    int unsigned gen_pos = 0;
    bit          drain_next = 1'b0;

    function automatic void push_word(logic [7:0] b, logic [2:0] k, logic r);
        reply_word_t w;
        bit          gaps_on;
        gaps_on = ((words_to_send.size() / 120) % 3) != 2;
        w.b = b;
        w.k = k;
        w.r = r;
        w.gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        w.drain = drain_next;
        drain_next = 1'b0;
        words_to_send.push_back(w);
        if (r)
            gen_pos = 0;
        if (gen_pos < FRAME_BODY)
            gen_pos++;
        else
            gen_pos = 0;
    endfunction

    function automatic void push_frame(logic [2:0] k, logic [7:0] v1, logic [7:0] v2,
                                       logic [7:0] v3, logic [2:0] flaws, int count);
        logic [7:0] f [FRAME_LEN];
        logic [7:0] sum;
        int         first_res;
        logic       r0;
        case (kind_t'(k))
            KIND_VOLTAGE, KIND_CURRENT, KIND_ENERGY: first_res = 4;
            KIND_POWER:                              first_res = 3;
            default:                                 first_res = 1;
        endcase
        f[0] = HEADER_BASE + {5'd0, k};
        f[1] = v1;
        f[2] = v2;
        f[3] = v3;
        f[4] = 8'd0;
        f[5] = 8'd0;
        for (int i = first_res; i < FRAME_BODY; i++)
            f[i] = 8'd0;
        if (flaws & FLAW_HEADER)
            f[0] = f[0] + 8'($urandom_range(1, 255));
        if (flaws & FLAW_RESERVED)
            f[$urandom_range(first_res, FRAME_BODY - 1)] = 8'($urandom_range(1, 255));
        sum = 8'd0;
        for (int i = 0; i < FRAME_BODY; i++)
            sum = sum + f[i];
        f[FRAME_BODY] = sum;
        if (flaws & FLAW_SUM)
            f[FRAME_BODY] = sum + 8'($urandom_range(1, 255));
        r0 = (gen_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                push_word(f[0], k, r0);
            else
                push_word(f[i], 3'($urandom_range(0, 7)), 1'b0);   // kind ignored here
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: advance to the next word after each handshake, hold a stalled
    // word, insert the idle gaps and the drain pause carried by the words.
    // ------------------------------------------------------------------------
    int unsigned gap_left = 0;
    bit          gap_served = 1'b0;
    reply_word_t next_word;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_reply_byte(rx_byte, expected_kind, restart);
            calm = words_to_send.size() < CALM_TAIL;
            if (in_valid && in_stall)
            begin
                // hold the stalled word as it is
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (words_to_send.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (!gap_served && words_to_send[0].gap != 0)
            begin
                gap_left = words_to_send[0].gap - 1;
                gap_served = 1'b1;
                in_valid <= 1'b0;
            end
            else if (words_to_send[0].drain && readings_due.size() != 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_word = words_to_send.pop_front();
                gap_served = 1'b0;
                rx_byte <= next_word.b;
                expected_kind <= next_word.k;
                restart <= next_word.r;
                in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest pending reading,
    // and drive out_stall in random bursts outside the quiet bands.
    // ------------------------------------------------------------------------
    int unsigned    stall_left = 0;
    int unsigned    cycle_cnt = 0;
    meter_reading_t due;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cycle_cnt++;
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected result: reading %0d kind %0d error_code %0d",
                           reading, reading_kind, error_code);
                    fails++;
                end
                else
                begin
                    due = readings_due.pop_front();
                    if (reading !== due.reading)
                    begin
                        $error("reading: expected %0d, actual %0d", due.reading, reading);
                        fails++;
                    end
                    if (reading_kind !== due.kind)
                    begin
                        $error("reading_kind: expected %0d, actual %0d",
                               due.kind, reading_kind);
                        fails++;
                    end
                    if (error_code !== due.err)
                    begin
                        $error("error_code: expected %0d, actual %0d", due.err, error_code);
                        fails++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && ((cycle_cnt / 256) % 3) != 2 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    int          frames_made;
    int unsigned pick;
    logic [2:0]  gen_kind;
    logic [2:0]  gen_flaws;

    initial
    begin
        frames_made = 0;

        // Directed: a cut-off voltage frame, then a restart into the largest
        // energy reading, the largest voltage reading, an undefined kind that
        // decodes like test, and a current frame with checksum and reserved
        // faults both present (checksum must win).
        push_word(HEADER_BASE, KIND_VOLTAGE, 1'b1);
        push_word(8'hFF, KIND_ENERGY, 1'b0);
        push_frame(KIND_ENERGY, 8'hFF, 8'hFF, 8'hFF, FLAW_NONE, FRAME_LEN);
        push_frame(KIND_VOLTAGE, 8'hFF, 8'hFF, 8'hFF, FLAW_NONE, FRAME_LEN);
        push_frame(3'd7, 8'h00, 8'h00, 8'h00, FLAW_NONE, FRAME_LEN);
        push_frame(KIND_CURRENT, 8'h00, 8'h00, 8'h00, FLAW_SUM | FLAW_RESERVED, FRAME_LEN);

        // Random: mostly well-formed frames with random content and faults,
        // some cut-off frames and loose noise bytes.
        while (words_to_send.size() < WORD_TARGET)
        begin
            pick = $urandom_range(0, 19);
            gen_kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
            gen_flaws = FLAW_NONE;
            if ($urandom_range(0, 7) == 0)
                gen_flaws = gen_flaws | FLAW_HEADER;
            if ($urandom_range(0, 7) == 0)
                gen_flaws = gen_flaws | FLAW_SUM;
            if ($urandom_range(0, 7) == 0)
                gen_flaws = gen_flaws | FLAW_RESERVED;
            if (pick < 2)
            begin
                repeat ($urandom_range(1, 4))
                    push_word(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 3) == 0));
            end
            else if (pick < 4)
            begin
                push_frame(gen_kind, pick_byte(), pick_byte(), pick_byte(), gen_flaws,
                           $urandom_range(1, FRAME_BODY));
            end
            else
            begin
                // pause the sender for a full drain now and then
                if (frames_made % 60 == 1)
                    drain_next = 1'b1;
                push_frame(gen_kind, pick_byte(), pick_byte(), pick_byte(), gen_flaws,
                           FRAME_LEN);
                frames_made++;
            end
        end

        // drop the gaps in the tail of the run
        for (int i = words_to_send.size() - CALM_TAIL; i < words_to_send.size(); i++)
            words_to_send[i].gap = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (words_to_send.size() != 0 || in_valid || readings_due.size() != 0);
        repeat (8) @(posedge clk);

        if (fails == 0 && readings_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mrfd_pkg.sv
design/mrfd_assembler.sv
design/mrfd_decode.sv
design/meter_response_frame_decoder_unit.sv
design/mrfd_checker.sv
test/tb_top.sv
